/* src/lcm_pkg.sv */
package lcm_pkg;

    // Converter sample width; the measurement and result fields stay fixed.
    localparam int RAW_WIDTH  = 16;
    localparam int DIFF_WIDTH = RAW_WIDTH + 1;
    localparam int MEAS_WIDTH = 17;
    localparam int MEAS_LIM   = 65535;

    localparam int PADDR_WIDTH = 5;

    // Input operation codes.
    localparam logic [1:0] OP_SLOT    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_DIFF_MODE = 3'd0;
    localparam logic [2:0] REG_POS_CHAN  = 3'd1;
    localparam logic [2:0] REG_NEG_CHAN  = 3'd2;
    localparam logic [2:0] REG_TARE      = 3'd3;
    localparam logic [2:0] REG_SCALE     = 3'd4;
    localparam logic [2:0] REG_ALPHA     = 3'd5;
    localparam logic [2:0] REG_DEADBAND  = 3'd6;
    localparam logic [2:0] REG_TIMEOUT   = 3'd7;

    localparam logic [16:0]        ALPHA_MIN = 17'd655;
    localparam logic [16:0]        ALPHA_MAX = 17'd65536;
    // 9.80665 in Q.24
    localparam logic signed [32:0] G_Q24     = 33'sd164528285;

    typedef enum logic [1:0] {
        JOB_REPORT_OK,
        JOB_REPORT_FAIL,
        JOB_TICK,
        JOB_RESTART
    } lcm_job_kind_t;

    typedef struct packed {
        lcm_job_kind_t                 kind;
        logic signed [MEAS_WIDTH-1:0]  meas;
    } lcm_job_t;

    typedef struct packed {
        logic                differential_mode;
        logic [2:0]          positive_channel;
        logic [2:0]          negative_channel;
        logic signed [16:0]  tare_counts;
        logic signed [31:0]  scale_per_count;
        logic [16:0]         filter_alpha;
        logic [15:0]         deadband_counts;
        logic [15:0]         timeout_ms;
    } lcm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_MASS,
        ST_MASS,
        ST_MUL_EMA,
        ST_EMA,
        ST_MUL_FORCE,
        ST_FORCE,
        ST_EMIT
    } lcm_state_t;

endpackage

/* src/lcm_in_if.sv */
interface lcm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            op;
    logic signed [4:0]                     slot_channel;
    logic signed [lcm_pkg::RAW_WIDTH-1:0]  slot_raw;
    logic                                  slot_last;

    modport source (output valid, op, slot_channel, slot_raw, slot_last, input ready);
    modport sink   (input valid, op, slot_channel, slot_raw, slot_last, output ready);
endinterface

/* src/lcm_out_if.sv */
interface lcm_out_if;
    logic                valid;
    logic                ready;
    logic signed [16:0]  measurement_raw;
    logic signed [31:0]  filtered_mass;
    logic signed [35:0]  force_res;
    logic                valid_res;

    modport source (output valid, measurement_raw, filtered_mass, force_res, valid_res,
                     input ready);
    modport sink   (input valid, measurement_raw, filtered_mass, force_res, valid_res,
                     output ready);
endinterface

/* src/lcm_regs.sv */
module lcm_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lcm_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output lcm_pkg::lcm_cfg_t                  cfg
);

    lcm_pkg::lcm_cfg_t cfg_reg;
    lcm_pkg::lcm_cfg_t cfg_next;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                lcm_pkg::REG_DIFF_MODE: cfg_next.differential_mode = pwdata[0];
                lcm_pkg::REG_POS_CHAN:  cfg_next.positive_channel  = pwdata[2:0];
                lcm_pkg::REG_NEG_CHAN:  cfg_next.negative_channel  = pwdata[2:0];
                lcm_pkg::REG_TARE:      cfg_next.tare_counts       = pwdata[16:0];
                lcm_pkg::REG_SCALE:     cfg_next.scale_per_count   = pwdata;
                lcm_pkg::REG_ALPHA:     cfg_next.filter_alpha      = pwdata[16:0];
                lcm_pkg::REG_DEADBAND:  cfg_next.deadband_counts   = pwdata[15:0];
                lcm_pkg::REG_TIMEOUT:   cfg_next.timeout_ms        = pwdata[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.differential_mode <= 1'b1;
            cfg_reg.positive_channel  <= 3'd0;
            cfg_reg.negative_channel  <= 3'd1;
            cfg_reg.tare_counts       <= '0;
            cfg_reg.scale_per_count   <= '0;
            cfg_reg.filter_alpha      <= 17'd16384;
            cfg_reg.deadband_counts   <= '0;
            cfg_reg.timeout_ms        <= 16'd200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            lcm_pkg::REG_DIFF_MODE: prdata = {31'd0, cfg_reg.differential_mode};
            lcm_pkg::REG_POS_CHAN:  prdata = {29'd0, cfg_reg.positive_channel};
            lcm_pkg::REG_NEG_CHAN:  prdata = {29'd0, cfg_reg.negative_channel};
            lcm_pkg::REG_TARE:      prdata = {15'd0, cfg_reg.tare_counts};
            lcm_pkg::REG_SCALE:     prdata = cfg_reg.scale_per_count;
            lcm_pkg::REG_ALPHA:     prdata = {15'd0, cfg_reg.filter_alpha};
            lcm_pkg::REG_DEADBAND:  prdata = {16'd0, cfg_reg.deadband_counts};
            lcm_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg_reg.timeout_ms};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

/* src/lcm_front.sv */
module lcm_front (
    input  logic               clk,
    input  logic               rst_n,
    lcm_in_if.sink             slot_in,
    input  lcm_pkg::lcm_cfg_t  cfg,
    output logic               push,
    output lcm_pkg::lcm_job_t  push_job,
    input  logic               push_ready
);

    logic signed [lcm_pkg::RAW_WIDTH-1:0]  pos_capture_reg, pos_capture_next;
    logic signed [lcm_pkg::RAW_WIDTH-1:0]  neg_capture_reg, neg_capture_next;
    logic                                  pos_seen_reg, pos_seen_next;
    logic                                  neg_seen_reg, neg_seen_next;

    logic                                  accept;
    logic                                  pos_match, neg_match;
    logic                                  pos_hit, neg_hit;
    logic signed [lcm_pkg::RAW_WIDTH-1:0]  pos_eff, neg_eff;
    logic                                  pos_seen_eff, neg_seen_eff;
    logic signed [lcm_pkg::DIFF_WIDTH-1:0] diff_w;
    logic signed [lcm_pkg::MEAS_WIDTH-1:0] meas;
    logic                                  report_ok;

    assign slot_in.ready = push_ready;
    assign accept        = slot_in.valid && push_ready;

    // Channel ids above 7 and the unused marker never match a 3-bit channel.
    assign pos_match = (slot_in.slot_channel[4:3] == 2'b00)
                    && (slot_in.slot_channel[2:0] == cfg.positive_channel);
    assign neg_match = (slot_in.slot_channel[4:3] == 2'b00)
                    && (slot_in.slot_channel[2:0] == cfg.negative_channel);

    always_comb
    begin
        pos_hit      = !pos_seen_reg && pos_match;
        neg_hit      = cfg.differential_mode && !neg_seen_reg && neg_match;
        pos_eff      = pos_hit ? slot_in.slot_raw : pos_capture_reg;
        neg_eff      = neg_hit ? slot_in.slot_raw : neg_capture_reg;
        pos_seen_eff = pos_seen_reg || pos_hit;
        neg_seen_eff = neg_seen_reg || neg_hit;
        report_ok    = pos_seen_eff && (!cfg.differential_mode || neg_seen_eff);

        if (cfg.differential_mode)
            diff_w = lcm_pkg::DIFF_WIDTH'(pos_eff) - lcm_pkg::DIFF_WIDTH'(neg_eff);
        else
            diff_w = lcm_pkg::DIFF_WIDTH'(pos_eff);

        if (diff_w > lcm_pkg::MEAS_LIM)
            meas = lcm_pkg::MEAS_WIDTH'(lcm_pkg::MEAS_LIM);
        else if (diff_w < -lcm_pkg::MEAS_LIM)
            meas = lcm_pkg::MEAS_WIDTH'(-lcm_pkg::MEAS_LIM);
        else
            meas = lcm_pkg::MEAS_WIDTH'(diff_w);
    end

    always_comb
    begin
        push          = 1'b0;
        push_job.meas = meas;
        push_job.kind = lcm_pkg::JOB_TICK;
        case (slot_in.op)
            lcm_pkg::OP_SLOT:
            begin
                push          = accept && slot_in.slot_last;
                push_job.kind = report_ok ? lcm_pkg::JOB_REPORT_OK : lcm_pkg::JOB_REPORT_FAIL;
            end
            lcm_pkg::OP_TICK:
            begin
                push          = accept;
                push_job.kind = lcm_pkg::JOB_TICK;
            end
            lcm_pkg::OP_RESTART:
            begin
                push          = accept;
                push_job.kind = lcm_pkg::JOB_RESTART;
            end
            default:
            begin
                push          = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_capture_next = pos_capture_reg;
        neg_capture_next = neg_capture_reg;
        pos_seen_next    = pos_seen_reg;
        neg_seen_next    = neg_seen_reg;
        if (accept && (slot_in.op == lcm_pkg::OP_SLOT))
        begin
            pos_capture_next = pos_eff;
            neg_capture_next = neg_eff;
            // The capture flags always clear at the end of a report.
            pos_seen_next    = slot_in.slot_last ? 1'b0 : pos_seen_eff;
            neg_seen_next    = slot_in.slot_last ? 1'b0 : neg_seen_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_capture_reg <= pos_capture_next;
        neg_capture_reg <= neg_capture_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_seen_reg <= 1'b0;
            neg_seen_reg <= 1'b0;
        end
        else
        begin
            pos_seen_reg <= pos_seen_next;
            neg_seen_reg <= neg_seen_next;
        end
    end

endmodule

/* src/lcm_queue.sv */
module lcm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcm_pkg::lcm_job_t  push_job,
    output logic               push_ready,
    input  logic               pop,
    output lcm_pkg::lcm_job_t  pop_job,
    output logic               pop_valid
);

    lcm_pkg::lcm_job_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/lcm_back.sv */
module lcm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lcm_pkg::lcm_cfg_t  cfg,
    input  logic               q_valid,
    input  lcm_pkg::lcm_job_t  q_job,
    output logic               q_pop,
    lcm_out_if.source          result_out
);

    function automatic logic signed [65:0] round_shr(input logic signed [65:0] v,
                                                     input int n);
        round_shr = (v + (66'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if ((&v[65:31]) || !(|v[65:31]))
            sat32 = v[31:0];
        else
            sat32 = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [35:0] sat36(input logic signed [65:0] v);
        if ((&v[65:35]) || !(|v[65:35]))
            sat36 = v[35:0];
        else
            sat36 = v[65] ? 36'sh8_0000_0000 : 36'sh7_FFFF_FFFF;
    endfunction

    lcm_pkg::lcm_state_t   state_reg, state_next;

    logic signed [32:0]    op_a_reg, op_a_next;
    logic signed [32:0]    op_b_reg, op_b_next;
    logic signed [65:0]    prod_reg;
    logic signed [31:0]    filt_reg, filt_next;
    logic                  primed_reg, primed_next;
    logic signed [35:0]    force_reg, force_next;
    logic                  valid_flag_reg, valid_flag_next;
    logic                  sample_seen_reg, sample_seen_next;
    logic [15:0]           age_reg, age_next;
    logic signed [16:0]    last_meas_reg, last_meas_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [16:0]    out_meas_reg, out_meas_next;
    logic signed [31:0]    out_mass_reg, out_mass_next;
    logic signed [35:0]    out_force_reg, out_force_next;
    logic                  out_flag_reg, out_flag_next;

    logic                  emit_load;
    logic signed [17:0]    delta;
    logic [17:0]           delta_mag;
    logic signed [17:0]    delta_db;
    logic [16:0]           alpha_c;
    logic [15:0]           age_inc;
    logic signed [31:0]    mass_sample;
    logic signed [31:0]    ema_val;

    assign q_pop     = (state_reg == lcm_pkg::ST_IDLE) && q_valid;
    assign emit_load = (state_reg == lcm_pkg::ST_EMIT)
                    && (!out_valid_reg || result_out.ready);

    // Shared datapath terms.
    always_comb
    begin
        delta     = 18'(q_job.meas) - 18'(cfg.tare_counts);
        delta_mag = delta[17] ? 18'(-delta) : 18'(delta);
        delta_db  = (delta_mag < 18'(cfg.deadband_counts)) ? 18'sd0 : delta;

        if (cfg.filter_alpha < lcm_pkg::ALPHA_MIN)
            alpha_c = lcm_pkg::ALPHA_MIN;
        else if (cfg.filter_alpha > lcm_pkg::ALPHA_MAX)
            alpha_c = lcm_pkg::ALPHA_MAX;
        else
            alpha_c = cfg.filter_alpha;

        age_inc     = (age_reg != 16'hFFFF) ? age_reg + 16'd1 : age_reg;
        mass_sample = sat32(round_shr(prod_reg, 20));
        // f + a*(m - f) is the same sum as a*m + (1 - a)*f.
        ema_val     = sat32(round_shr((66'(filt_reg) <<< 16) + prod_reg, 16));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcm_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_job.kind)
                        lcm_pkg::JOB_REPORT_OK:   state_next = lcm_pkg::ST_MUL_MASS;
                        lcm_pkg::JOB_REPORT_FAIL: state_next = lcm_pkg::ST_EMIT;
                        lcm_pkg::JOB_TICK:        state_next = lcm_pkg::ST_EMIT;
                        default:                  state_next = lcm_pkg::ST_IDLE;
                    endcase
                end
            end
            lcm_pkg::ST_MUL_MASS:  state_next = lcm_pkg::ST_MASS;
            lcm_pkg::ST_MASS:
                state_next = primed_reg ? lcm_pkg::ST_MUL_EMA : lcm_pkg::ST_MUL_FORCE;
            lcm_pkg::ST_MUL_EMA:   state_next = lcm_pkg::ST_EMA;
            lcm_pkg::ST_EMA:       state_next = lcm_pkg::ST_MUL_FORCE;
            lcm_pkg::ST_MUL_FORCE: state_next = lcm_pkg::ST_FORCE;
            lcm_pkg::ST_FORCE:     state_next = lcm_pkg::ST_EMIT;
            lcm_pkg::ST_EMIT:      state_next = emit_load ? lcm_pkg::ST_IDLE : lcm_pkg::ST_EMIT;
            default:               state_next = lcm_pkg::ST_IDLE;
        endcase
    end

    // State updates and operand selection.
    always_comb
    begin
        op_a_next        = op_a_reg;
        op_b_next        = op_b_reg;
        filt_next        = filt_reg;
        primed_next      = primed_reg;
        force_next       = force_reg;
        valid_flag_next  = valid_flag_reg;
        sample_seen_next = sample_seen_reg;
        age_next         = age_reg;
        last_meas_next   = last_meas_reg;
        out_meas_next    = out_meas_reg;
        out_mass_next    = out_mass_reg;
        out_force_next   = out_force_reg;
        out_flag_next    = out_flag_reg;
        out_valid_next   = out_valid_reg && !result_out.ready;

        case (state_reg)
            lcm_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_job.kind)
                        lcm_pkg::JOB_REPORT_OK:
                        begin
                            last_meas_next   = q_job.meas;
                            sample_seen_next = 1'b1;
                            age_next         = 16'd0;
                            op_a_next        = 33'(delta_db);
                            op_b_next        = 33'(cfg.scale_per_count);
                        end
                        lcm_pkg::JOB_REPORT_FAIL:
                        begin
                            valid_flag_next = 1'b0;
                        end
                        lcm_pkg::JOB_TICK:
                        begin
                            if (sample_seen_reg)
                            begin
                                age_next = age_inc;
                                if (age_inc > cfg.timeout_ms)
                                    valid_flag_next = 1'b0;
                            end
                        end
                        lcm_pkg::JOB_RESTART:
                        begin
                            filt_next   = 32'sd0;
                            primed_next = 1'b0;
                        end
                        default:
                        begin
                            filt_next = filt_reg;
                        end
                    endcase
                end
            end
            lcm_pkg::ST_MASS:
            begin
                if (primed_reg)
                begin
                    op_a_next = 33'(mass_sample) - 33'(filt_reg);
                    op_b_next = $signed({16'd0, alpha_c});
                end
                else
                begin
                    // The first sample loads the filter directly.
                    filt_next   = mass_sample;
                    primed_next = 1'b1;
                    op_a_next   = 33'(mass_sample);
                    op_b_next   = lcm_pkg::G_Q24;
                end
            end
            lcm_pkg::ST_EMA:
            begin
                filt_next = ema_val;
                op_a_next = 33'(ema_val);
                op_b_next = lcm_pkg::G_Q24;
            end
            lcm_pkg::ST_FORCE:
            begin
                force_next      = sat36(round_shr(prod_reg, 24));
                valid_flag_next = (cfg.scale_per_count != 32'sd0);
            end
            lcm_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_meas_next  = last_meas_reg;
                    out_mass_next  = filt_reg;
                    out_force_next = force_reg;
                    out_flag_next  = valid_flag_reg;
                end
            end
            default:
            begin
                op_a_next = op_a_reg;
            end
        endcase
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.measurement_raw = out_meas_reg;
    assign result_out.filtered_mass   = out_mass_reg;
    assign result_out.force_res       = out_force_reg;
    assign result_out.valid_res       = out_flag_reg;

    always_ff @(posedge clk)
    begin
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        prod_reg      <= op_a_reg * op_b_reg;
        out_meas_reg  <= out_meas_next;
        out_mass_reg  <= out_mass_next;
        out_force_reg <= out_force_next;
        out_flag_reg  <= out_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lcm_pkg::ST_IDLE;
            filt_reg        <= '0;
            primed_reg      <= 1'b0;
            force_reg       <= '0;
            valid_flag_reg  <= 1'b0;
            sample_seen_reg <= 1'b0;
            age_reg         <= '0;
            last_meas_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            filt_reg        <= filt_next;
            primed_reg      <= primed_next;
            force_reg       <= force_next;
            valid_flag_reg  <= valid_flag_next;
            sample_seen_reg <= sample_seen_next;
            age_reg         <= age_next;
            last_meas_reg   <= last_meas_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    a_primed_clear_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(primed_reg) |-> $past(q_pop && (q_job.kind == lcm_pkg::JOB_RESTART)))
        else $error("filter priming dropped without a restart");

    a_valid_set_at_force: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_flag_reg) |-> $past(state_reg == lcm_pkg::ST_FORCE))
        else $error("valid flag set outside the force step");

    a_age_idle_before_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_seen_reg |-> (age_reg == 16'd0))
        else $error("age advanced before any good sample");

    a_ema_only_when_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcm_pkg::ST_MUL_EMA) |-> primed_reg)
        else $error("EMA step taken on an unprimed filter");

endmodule

/* src/load_cell_mass_conditioner.sv */
// Channel     Dir  Handshake        Carries
// slot_in     in   valid/ready      op, slot_channel, slot_raw, slot_last
// result_out  out  valid/ready      measurement_raw, filtered_mass, force_res, valid_res
// apb         in   psel/penable     register writes and reads, pready tied high
//
// Slots, ticks, restarts and unused operations enter at one transaction per cycle while
// the two-entry job queue has room. A good report end runs up to three dependent products
// on the one multiplier (no EMA product on the first sample); a tick or a failed report
// goes straight to the emit step and a restart stays in idle. The output register holds
// a result while the back end starts the next job; a stalled output stalls the back end,
// then the queue, then the input. Reset is asynchronous, active low, with no clearing pass.
module load_cell_mass_conditioner (
    input  logic                             clk,
    input  logic                             rst_n,
    lcm_in_if.sink                           slot_in,
    lcm_out_if.source                        result_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lcm_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    lcm_pkg::lcm_cfg_t  cfg;
    logic               push;
    lcm_pkg::lcm_job_t  push_job;
    logic               push_ready;
    logic               pop;
    lcm_pkg::lcm_job_t  pop_job;
    logic               pop_valid;

    // Configuration registers. Software must write them only while the block is idle (not enforced).
    lcm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: captures the positive and negative slots of a report and turns
    // the last slot, ticks and restarts into jobs for the back end.
    lcm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_in    (slot_in),
        .cfg        (cfg),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    // Short job queue so that slots keep streaming while the back end computes.
    lcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid)
    );

    // Back end: deadband, scaling, EMA and force through one shared multiplier,
    // age and timeout tracking, and the result register.
    lcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (pop_valid),
        .q_job      (pop_job),
        .q_pop      (pop),
        .result_out (result_out)
    );

endmodule
